// File: src/pvbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvbd_pkg
// shared constants and controller/datapath types for the proximity volume core
// ----------------------------------------------------------------------------
package pvbd_pkg;

  localparam int COORD_W             = 20;
  localparam int SIZE_W              = 19;
  localparam int VOL_W               = 17;
  localparam int DIST_W              = 20;
  localparam int CUTOFF_W            = 12;
  localparam int SCALE_W             = 24;
  localparam int CFG_DATA_W          = 24;
  localparam int CFG_IDX_W           = 2;
  localparam int COORD_FRAC_BITS_DEF = 4;

  localparam int GAP_W   = 23;
  localparam int SQ_W    = 44;
  localparam int ROOT_STEPS = 22;
  localparam int DIV_STEPS  = 16;
  localparam int CNT_W      = 5;

  localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 12'd750;
  localparam logic [SCALE_W-1:0]  SCALE_RESET  = 24'd750000;
  localparam logic [VOL_W-1:0]    VOL_FULL     = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE   = 2'd2;

  typedef struct packed {
    logic load;
    logic gap;
    logic sq;
    logic sum;
    logic root;
    logic min;
    logic frame;
    logic mul_init1;
    logic mul_init2;
    logic mul_step;
    logic cmp;
    logic div_step;
    logic vol_zero;
    logic vol_full;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic corner;
    logic last;
    logic play;
    logic ambient;
    logic m_le0;
    logic m_ge_cq;
    logic num_ge_den;
  } status_t;

endpackage

// File: src/pvbd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvbd_in_if
// player and box pair channel
// ----------------------------------------------------------------------------
interface pvbd_in_if import pvbd_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  player_x;
  logic signed [COORD_W-1:0]  player_y;
  logic signed [COORD_W-1:0]  box_x;
  logic signed [COORD_W-1:0]  box_y;
  logic        [SIZE_W-1:0]   box_width;
  logic        [SIZE_W-1:0]   box_height;
  logic                       play_on;
  logic                       frame_last;

  modport source (output valid, player_x, player_y, box_x, box_y, box_width,
                  box_height, play_on, frame_last, input ready);
  modport sink   (input valid, player_x, player_y, box_x, box_y, box_width,
                  box_height, play_on, frame_last, output ready);
endinterface

// File: src/pvbd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvbd_out_if
// volume result channel
// ----------------------------------------------------------------------------
interface pvbd_out_if import pvbd_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic        [VOL_W-1:0]   volume;
  logic signed [DIST_W-1:0]  nearest_distance;

  modport source (output valid, volume, nearest_distance, input ready);
  modport sink   (input valid, volume, nearest_distance, output ready);
endinterface

// File: src/pvbd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvbd_dp
// datapath: gaps, squares, bit-serial root, frame minimum, cube and divide
// ----------------------------------------------------------------------------
module pvbd_dp import pvbd_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmd_t                      cmd,
  output status_t                   status,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,
  input  logic signed [COORD_W-1:0] in_px,
  input  logic signed [COORD_W-1:0] in_py,
  input  logic signed [COORD_W-1:0] in_bx,
  input  logic signed [COORD_W-1:0] in_by,
  input  logic [SIZE_W-1:0]         in_w,
  input  logic [SIZE_W-1:0]         in_h,
  input  logic                      in_play,
  input  logic                      in_last,
  output logic [VOL_W-1:0]          out_vol,
  output logic signed [DIST_W-1:0]  out_dist
);

  localparam int D     = CUTOFF_W + COORD_FRAC_BITS;
  // minimum holds negative inside distances as well as the cutoff
  localparam int RM_W  = (D + 1 > GAP_W - 2) ? D + 1 : GAP_W - 2;
  localparam int DEN_W = 3 * D;
  localparam int NUM_W = SCALE_W + 3 * COORD_FRAC_BITS;

  logic                      ambient_r;
  logic [CUTOFF_W-1:0]       cutoff_r;
  logic [SCALE_W-1:0]        scale_r;

  logic signed [COORD_W-1:0] px_r, py_r, bx_r, by_r;
  logic [SIZE_W-1:0]         w_r, h_r;
  logic                      play_r, last_r;

  logic signed [GAP_W-1:0]   gx_r, gy_r, d2_r;
  logic [SQ_W-1:0]           sqa_r, sqb_r, rad_r, root_r, bit_r;
  logic signed [RM_W-1:0]    rm_r, m_r;
  logic [DEN_W-1:0]          mcand_r, acc_r, rem_r;
  logic [D-1:0]              mplier_r;
  logic [VOL_W-1:0]          vol_r;
  logic [VOL_W-1:0]          out_vol_r;
  logic signed [DIST_W-1:0]  out_dist_r;

  logic signed [COORD_W:0]   dx, dy;
  logic [COORD_W:0]          adx, ady;
  logic signed [GAP_W-1:0]   gx, gy, d2v, dv, rmx;
  logic [SQ_W-1:0]           tsum;
  logic signed [RM_W-1:0]    cq;
  logic [DEN_W-1:0]          num;
  logic [DEN_W:0]            r2;

  assign dx   = {bx_r[COORD_W-1], bx_r} - {px_r[COORD_W-1], px_r};
  assign dy   = {by_r[COORD_W-1], by_r} - {py_r[COORD_W-1], py_r};
  assign adx  = dx[COORD_W] ? (~dx + 1'b1) : dx;
  assign ady  = dy[COORD_W] ? (~dy + 1'b1) : dy;
  assign gx   = $signed({1'b0, adx, 1'b0}) - $signed({3'b0, w_r});
  assign gy   = $signed({1'b0, ady, 1'b0}) - $signed({3'b0, h_r});
  assign tsum = root_r + bit_r;
  assign d2v  = status.corner ? $signed({1'b0, root_r[GAP_W-2:0]}) : d2_r;
  assign dv   = d2v >>> 1;
  assign rmx  = GAP_W'(rm_r);
  assign cq   = $signed(RM_W'(cutoff_r) << COORD_FRAC_BITS);
  assign num  = DEN_W'(NUM_W'(scale_r) << (3 * COORD_FRAC_BITS));
  assign r2   = {rem_r, 1'b0};

  assign status.corner     = !gx_r[GAP_W-1] && !gy_r[GAP_W-1];
  assign status.last       = last_r;
  assign status.play       = play_r;
  assign status.ambient    = ambient_r;
  assign status.m_le0      = m_r <= 0;
  assign status.m_ge_cq    = m_r >= cq;
  assign status.num_ge_den = num >= acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ambient_r <= 1'b1;
      cutoff_r  <= CUTOFF_RESET;
      scale_r   <= SCALE_RESET;
      rm_r      <= $signed(RM_W'(CUTOFF_RESET) << COORD_FRAC_BITS);
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_AMBIENT: ambient_r <= cfg_data[0];
          CFG_CUTOFF:  cutoff_r  <= cfg_data[CUTOFF_W-1:0];
          CFG_SCALE:   scale_r   <= cfg_data[SCALE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.min && (dv < rmx)) begin
        rm_r <= dv[RM_W-1:0];
      end else if (cmd.frame) begin
        rm_r <= cq;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      px_r   <= in_px;
      py_r   <= in_py;
      bx_r   <= in_bx;
      by_r   <= in_by;
      w_r    <= in_w;
      h_r    <= in_h;
      play_r <= in_play;
      last_r <= in_last;
    end
    if (cmd.gap) begin
      gx_r <= gx;
      gy_r <= gy;
    end
    if (cmd.sq) begin
      sqa_r <= gx_r[GAP_W-2:0] * gx_r[GAP_W-2:0];
      sqb_r <= gy_r[GAP_W-2:0] * gy_r[GAP_W-2:0];
      d2_r  <= gx_r[GAP_W-1] ? gy_r : gx_r;
    end
    if (cmd.sum) begin
      rad_r  <= sqa_r + sqb_r;
      root_r <= '0;
      bit_r  <= SQ_W'(1) << (2 * (ROOT_STEPS - 1));
    end
    if (cmd.root) begin
      if (rad_r >= tsum) begin
        rad_r  <= rad_r - tsum;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (cmd.frame) begin
      m_r <= (rm_r < cq) ? rm_r : cq;
    end
    if (cmd.mul_init1) begin
      mcand_r  <= DEN_W'(m_r[D-1:0]);
      mplier_r <= m_r[D-1:0];
      acc_r    <= '0;
    end
    if (cmd.mul_init2) begin
      mcand_r  <= acc_r;
      mplier_r <= m_r[D-1:0];
      acc_r    <= '0;
    end
    if (cmd.mul_step) begin
      if (mplier_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
    end
    if (cmd.cmp) begin
      rem_r <= num;
      vol_r <= '0;
    end
    if (cmd.div_step) begin
      if (r2 >= {1'b0, acc_r}) begin
        rem_r <= DEN_W'(r2 - {1'b0, acc_r});
        vol_r <= {vol_r[VOL_W-2:0], 1'b1};
      end else begin
        rem_r <= r2[DEN_W-1:0];
        vol_r <= {vol_r[VOL_W-2:0], 1'b0};
      end
    end
    if (cmd.vol_zero) begin
      vol_r <= '0;
    end
    if (cmd.vol_full) begin
      vol_r <= VOL_FULL;
    end
    if (cmd.emit) begin
      out_vol_r  <= vol_r;
      out_dist_r <= DIST_W'(m_r);
    end
  end

  assign out_vol  = out_vol_r;
  assign out_dist = out_dist_r;

endmodule

// File: src/pvbd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pvbd_ctrl
// sequencer for one pair at a time and the result handshake
// ----------------------------------------------------------------------------
module pvbd_ctrl import pvbd_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  output cmd_t    cmd,
  input  status_t status
);

  localparam int D = CUTOFF_W + COORD_FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_GAP, S_SQ, S_SUM, S_ROOT, S_MIN, S_FRAME, S_CLASS,
    S_CUBE1, S_MUL2, S_CUBE2, S_CMP, S_DIV, S_EMIT
  } state_t;

  state_t             state_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               out_valid_r;
  logic               emit_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign emit_ok   = !out_valid_r || out_ready;

  always_comb begin
    cmd = '0;
    unique case (state_r)
      S_IDLE:  cmd.load = in_valid;
      S_GAP:   cmd.gap = 1'b1;
      S_SQ:    cmd.sq = 1'b1;
      S_SUM:   cmd.sum = 1'b1;
      S_ROOT:  cmd.root = 1'b1;
      S_MIN:   cmd.min = 1'b1;
      S_FRAME: cmd.frame = 1'b1;
      S_CLASS: begin
        if (!status.play || status.m_ge_cq) begin
          cmd.vol_zero = 1'b1;
        end else if (status.m_le0) begin
          cmd.vol_full = 1'b1;
        end else begin
          cmd.mul_init1 = 1'b1;
        end
      end
      S_CUBE1: cmd.mul_step = 1'b1;
      S_MUL2:  cmd.mul_init2 = 1'b1;
      S_CUBE2: cmd.mul_step = 1'b1;
      S_CMP: begin
        cmd.cmp      = !status.num_ge_den;
        cmd.vol_full = status.num_ge_den;
      end
      S_DIV:   cmd.div_step = 1'b1;
      S_EMIT:  cmd.emit = emit_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_EMIT) && emit_ok) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE:  if (in_valid) state_r <= S_GAP;
        S_GAP:   state_r <= S_SQ;
        S_SQ:    state_r <= status.corner ? S_SUM : S_MIN;
        S_SUM: begin
          cnt_r   <= '0;
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(ROOT_STEPS - 1)) state_r <= S_MIN;
        end
        S_MIN:   state_r <= status.last ? S_FRAME : S_IDLE;
        S_FRAME: state_r <= status.ambient ? S_CLASS : S_IDLE;
        S_CLASS: begin
          cnt_r <= '0;
          if (!status.play || status.m_ge_cq || status.m_le0) begin
            state_r <= S_EMIT;
          end else begin
            state_r <= S_CUBE1;
          end
        end
        S_CUBE1: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(D - 1)) state_r <= S_MUL2;
        end
        S_MUL2: begin
          cnt_r   <= '0;
          state_r <= S_CUBE2;
        end
        S_CUBE2: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(D - 1)) state_r <= S_CMP;
        end
        S_CMP: begin
          cnt_r   <= '0;
          state_r <= status.num_ge_den ? S_EMIT : S_DIV;
        end
        S_DIV: begin
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNT_W'(DIV_STEPS - 1)) state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_ok) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result overwritten before transfer");

  a_root_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROOT) |-> status.corner)
    else $error("root taken for a side gap");

  a_cube_positive: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CUBE1) |-> (!status.m_le0 && !status.m_ge_cq))
    else $error("cube started outside the volume range");

  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r)
    else $error("emitted result not shown");

endmodule

// File: src/proximity_volume_from_box_distance_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// proximity_volume_from_box_distance_core
// frame minimum point-to-box distance and cubic falloff volume
// ----------------------------------------------------------------------------
// channel  dir  transfer on       payload
// in_ch    in   valid && ready    player/box pair, play flag, frame_last
// out_ch   out  valid && ready    volume, nearest_distance
// cfg_*    in   cfg_we            register index and data
//
// a side pair passes gap, square and minimum; a corner pair adds sum and a 22-step root
// a frame's last pair adds the frame step and, when ambient and in range, the cube and divide
// synchronous reset, no clearing pass
// the output register holds a result while the next pair is taken
// a stalled output holds the block only when the next result is ready
module proximity_volume_from_box_distance_core import pvbd_pkg::*; #(
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  pvbd_in_if.sink               in_ch,
  pvbd_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t    cmd;
  status_t status;

  pvbd_ctrl #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  pvbd_dp #(.COORD_FRAC_BITS(COORD_FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_px     (in_ch.player_x),
    .in_py     (in_ch.player_y),
    .in_bx     (in_ch.box_x),
    .in_by     (in_ch.box_y),
    .in_w      (in_ch.box_width),
    .in_h      (in_ch.box_height),
    .in_play   (in_ch.play_on),
    .in_last   (in_ch.frame_last),
    .out_vol   (out_ch.volume),
    .out_dist  (out_ch.nearest_distance)
  );

endmodule
